// ===== hw/rtl/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 shared definitions
// Round constants, initial hash values and round helper functions.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef logic [31:0] word_t;

  function automatic word_t round_k(input logic [5:0] r);
    case (r)
      6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;  default: round_k = 32'hc67178f2;
    endcase
  endfunction

  function automatic word_t init_hash(input logic [2:0] i);
    case (i)
      3'd0: init_hash = 32'h6a09e667;
      3'd1: init_hash = 32'hbb67ae85;
      3'd2: init_hash = 32'h3c6ef372;
      3'd3: init_hash = 32'ha54ff53a;
      3'd4: init_hash = 32'h510e527f;
      3'd5: init_hash = 32'h9b05688c;
      3'd6: init_hash = 32'h1f83d9ab;
      default: init_hash = 32'h5be0cd19;
    endcase
  endfunction

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  // control from the sequencer to the compression core
  typedef struct packed {
    logic       start;   // load working vars from chain value and schedule from block
    logic       round;   // run one round
    logic       fold;    // add working vars into chain value
    logic       reinit;  // reload initial hash values
    logic [5:0] rnd;     // round number
  } core_ctl_t;

endpackage

// ===== hw/rtl/sha_core.sv =====
// ----------------------------------------------------------------------------
// SHA-256 compression core
// One round unit applied once per cycle while ctl.round is set, rolling 16-word schedule window.
// ----------------------------------------------------------------------------
module sha_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  sha_pkg::core_ctl_t      ctl,
  input  sha_pkg::word_t [15:0]   block,
  input  logic [2:0]              rd_idx,
  output sha_pkg::word_t          rd_word
);
  import sha_pkg::*;

  word_t [7:0]  chain_r, chain_nxt;
  word_t [7:0]  wv_r, wv_nxt;
  word_t [15:0] win_r, win_nxt;

  word_t w, s0, s1, t1, t2, a, e;

  always_comb begin
    a  = wv_r[0];
    e  = wv_r[4];
    s1 = rotr(win_r[14], 17) ^ rotr(win_r[14], 19) ^ (win_r[14] >> 10);
    s0 = rotr(win_r[1], 7) ^ rotr(win_r[1], 18) ^ (win_r[1] >> 3);
    // window holds w[r..r+15] at index 0..15; shift every round
    w  = (ctl.rnd < 6'd16) ? win_r[0] : win_r[0];
    t1 = wv_r[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
       + ((e & wv_r[5]) ^ (~e & wv_r[6])) + round_k(ctl.rnd) + w;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
       + ((a & wv_r[1]) ^ (a & wv_r[2]) ^ (wv_r[1] & wv_r[2]));
    chain_nxt = chain_r;
    wv_nxt    = wv_r;
    win_nxt   = win_r;
    if (ctl.start) begin
      wv_nxt  = chain_r;
      win_nxt = block;
    end else if (ctl.round) begin
      wv_nxt = {wv_r[6:4], wv_r[3] + t1, wv_r[2:0], t1 + t2};
      // new word w[r+16] = s1(w[r+14]) + w[r+9] + s0(w[r+1]) + w[r]
      win_nxt = {s1 + win_r[9] + s0 + win_r[0], win_r[15:1]};
    end
    if (ctl.fold) begin
      for (int j = 0; j < 8; j++) chain_nxt[j] = chain_r[j] + wv_r[j];
    end
    if (ctl.reinit) begin
      for (int j = 0; j < 8; j++) chain_nxt[j] = init_hash(3'(j));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < 8; j++) chain_r[j] <= init_hash(3'(j));
    end else begin
      chain_r <= chain_nxt;
    end
    wv_r  <= wv_nxt;
    win_r <= win_nxt;
  end

  assign rd_word = chain_r[rd_idx];

endmodule

// ===== hw/rtl/sha256_stream_hasher.sv =====
// Flow: a byte that fills no block is taken while the hasher is idle; a full block
//   is then compressed (load, 64 rounds, fold) on the shared round unit.
// End of message: one or two padded blocks, then eight digest
//   transfers, one per cycle while out_tready is high.
// Throughput: one byte per cycle, but in_tready is low while each 64-byte block is compressed.
// Reset: synchronous active-low rst_n reloads the initial hash and clears counts.
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte stream in, eight digest words out per message.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tuser,   // byte_present
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // digest_word
  output logic [2:0]  out_tuser,  // word_index
  output logic        out_tlast   // last_word
);
  import sha_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_ROUND = 5'b00100,
    S_FOLD  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t        state_r, state_nxt;
  word_t [15:0]  blk_r, blk_nxt;
  logic [63:0]   cnt_r, cnt_nxt;
  logic [5:0]    rnd_r, rnd_nxt;
  logic [2:0]    oidx_r, oidx_nxt;
  logic          fin_r, fin_nxt;     // finishing message
  logic          lenblk_r, lenblk_nxt; // length block still to compress
  core_ctl_t     ctl;
  word_t         dig;

  logic          acc;
  logic [5:0]    pos;
  logic [63:0]   cnt_inc;
  logic [63:0]   bits;

  assign acc = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    blk_nxt    = blk_r;
    cnt_nxt    = cnt_r;
    rnd_nxt    = rnd_r;
    oidx_nxt   = oidx_r;
    fin_nxt    = fin_r;
    lenblk_nxt = lenblk_r;
    ctl        = '0;
    ctl.rnd    = rnd_r;
    cnt_inc    = cnt_r;
    pos        = 6'd0;
    bits       = 64'd0;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_tuser) begin
            pos = cnt_r[5:0];
            if (pos[1:0] == 2'd0) blk_nxt[pos[5:2]] = {in_tdata, 24'd0};
            else blk_nxt[pos[5:2]][(3 - pos[1:0]) * 8 +: 8] = in_tdata;
            cnt_inc = cnt_r + 64'd1;
          end
          cnt_nxt = cnt_inc;
          fin_nxt = in_tlast;
          if (in_tuser && pos == 6'd63) begin
            // an end byte that closes a block still needs pad and length
            state_nxt = S_START;
            lenblk_nxt = in_tlast;
          end else if (in_tlast) begin
            pos  = cnt_inc[5:0];
            bits = cnt_inc << 3;
            blk_nxt[pos[5:2]][(3 - pos[1:0]) * 8 +: 8] = PAD_BYTE;
            for (int b = 0; b < 3; b++)
              if (b < 3 - int'(pos[1:0])) blk_nxt[pos[5:2]][b * 8 +: 8] = 8'd0;
            for (int j = 0; j < 16; j++)
              if (j > int'(pos[5:2])) blk_nxt[j] = '0;
            if (pos < 6'd56) begin
              blk_nxt[14] = bits[63:32];
              blk_nxt[15] = bits[31:0];
              lenblk_nxt = 1'b0;
            end else begin
              lenblk_nxt = 1'b1;
            end
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        ctl.start = 1'b1;
        rnd_nxt   = 6'd0;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        ctl.round = 1'b1;
        rnd_nxt   = rnd_r + 6'd1;
        if (rnd_r == 6'd63) state_nxt = S_FOLD;
      end
      S_FOLD: begin
        ctl.fold = 1'b1;
        bits = cnt_r << 3;
        if (!fin_r) begin
          state_nxt = S_IDLE;
        end else if (lenblk_r) begin
          blk_nxt     = '0;
          // message ended on a block border: pad byte opens this block
          if (cnt_r[5:0] == 6'd0) blk_nxt[0] = {PAD_BYTE, 24'd0};
          blk_nxt[14] = bits[63:32];
          blk_nxt[15] = bits[31:0];
          lenblk_nxt  = 1'b0;
          state_nxt   = S_START;
        end else begin
          oidx_nxt  = 3'd0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_tready) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            ctl.reinit = 1'b1;
            cnt_nxt    = '0;
            fin_nxt    = 1'b0;
            state_nxt  = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      rnd_r    <= '0;
      oidx_r   <= '0;
      fin_r    <= 1'b0;
      lenblk_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      rnd_r    <= rnd_nxt;
      oidx_r   <= oidx_nxt;
      fin_r    <= fin_nxt;
      lenblk_r <= lenblk_nxt;
    end
    blk_r <= blk_nxt;
  end

  sha_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .block   (blk_r),
    .rd_idx  (oidx_r),
    .rd_word (dig)
  );

  assign out_tvalid = (state_r == S_EMIT);
  assign out_tdata  = dig;
  assign out_tuser  = oidx_r;
  assign out_tlast  = (oidx_r == 3'd7);

`ifndef SYNTH
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input ready while emitting");
  a_round_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FOLD) |-> $past(rnd_r) == 6'd63) else $error("fold before round 63");
  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid && $stable(oidx_r))
    else $error("digest index moved while stalled");
`endif

endmodule
